>>> rtl/mspt_pkg.sv
// ----------------------------------------------------------------------------
// mspt_pkg: shared types for the multi-slot timer
// Word layouts, operation codes and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package mspt_pkg;

	localparam int SLOTS_DEF = 16;
	localparam int TIME_W    = 32;
	localparam int MASK_W    = 16;
	localparam int OUT_IDX_W = 4;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_START  = 2'd1,
		OP_STOP   = 2'd2,
		OP_REPEAT = 2'd3
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [3:0]        timer_slot;
		logic [TIME_W-1:0] first_delay;
		logic [TIME_W-1:0] period;
	} in_word_t;

	typedef struct packed {
		logic [MASK_W-1:0]    fired_mask;
		logic [OUT_IDX_W-1:0] assigned_slot;
		logic                 table_full;
		logic [TIME_W-1:0]    now_ms;
	} out_word_t;

	typedef struct packed {
		logic latch;
		logic prep;
		logic now_inc;
		logic scan_rd;
		logic idx_inc;
		logic alloc;
		logic set_full;
		logic stop_do;
		logic rep_do;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic idx_last;
		logic cur_free;
		logic out_room;
	} status_t;

endpackage

>>> rtl/mspt_ctrl.sv
// ----------------------------------------------------------------------------
// mspt_ctrl: sequencer for the multi-slot timer
// Accepts one word, walks the slot table as the operation requires and hands
// the finished result to the output register.
// ----------------------------------------------------------------------------
module mspt_ctrl
	import mspt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_DECODE = 6'b000010,
		ST_SCAN   = 6'b000100,
		ST_DRAIN  = 6'b001000,
		ST_FIND   = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.prep = 1'b1;
				case (status.op)
					OP_TICK: begin
						cmd.now_inc = 1'b1;
						state_d     = ST_SCAN;
					end
					OP_START: state_d = ST_FIND;
					OP_STOP: begin
						cmd.stop_do = 1'b1;
						state_d     = ST_DONE;
					end
					OP_REPEAT: begin
						cmd.rep_do = 1'b1;
						state_d    = ST_DONE;
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (status.idx_last) begin
					state_d = ST_DRAIN;
				end
			end
			// The last slot read is compared in this cycle.
			ST_DRAIN: state_d = ST_DONE;
			ST_FIND: begin
				if (status.cur_free) begin
					cmd.alloc = 1'b1;
					state_d   = ST_DONE;
				end else if (status.idx_last) begin
					cmd.set_full = 1'b1;
					state_d      = ST_DONE;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			ST_DONE: begin
				if (status.out_room) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/mspt_dp.sv
// ----------------------------------------------------------------------------
// mspt_dp: datapath of the multi-slot timer
// Time counter, slot flags, slot memories, the one-slot-per-cycle compare
// stage and the output register.
// ----------------------------------------------------------------------------
module mspt_dp
	import mspt_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      cmd,
	output status_t   status,
	input  in_word_t  in_data,
	input  logic      out_stall,
	output logic      out_valid,
	output out_word_t out_data
);

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	in_word_t          item_q;
	logic [TIME_W-1:0] now_q;
	logic [SW-1:0]     idx_q;
	logic [SLOTS-1:0]  slot_valid_q;
	logic [SLOTS-1:0]  slot_fired_q;

	logic [TIME_W-1:0] ref_mem [SLOTS];
	logic [TIME_W-1:0] dly_mem [SLOTS];
	logic [TIME_W-1:0] per_mem [SLOTS];

	logic              rd_s1;
	logic [SW-1:0]     idx_s1;
	logic [TIME_W-1:0] ref_s1;
	logic [TIME_W-1:0] dly_s1;
	logic [TIME_W-1:0] per_s1;

	logic [MASK_W-1:0]    mask_q;
	logic [OUT_IDX_W-1:0] assigned_q;
	logic                 full_q;
	out_word_t            out_q;
	logic                 out_valid_q;

	logic [SW-1:0]     slot_sel;
	logic              slot_hit;
	logic [TIME_W-1:0] elapsed;
	logic [TIME_W-1:0] limit;
	logic              fire;
	logic              ref_we;
	logic [SW-1:0]     ref_wa;
	logic [TIME_W-1:0] per_wd;
	logic [SW-1:0]     per_wa;
	logic              per_we;

	// A slot number beyond the table never matches a live slot.
	assign slot_sel = SW'(item_q.timer_slot);
	assign slot_hit = (32'(item_q.timer_slot) < 32'(SLOTS)) && slot_valid_q[slot_sel];

	// Before its first firing a slot counts from its start time against the
	// first delay, afterwards from its last firing against the period.
	assign elapsed = now_q - ref_s1;
	assign limit   = slot_fired_q[idx_s1] ? per_s1 : dly_s1;
	assign fire    = rd_s1 && slot_valid_q[idx_s1] && (elapsed >= limit);

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			item_q <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= '0;
		end else if (cmd.now_inc) begin
			now_q <= now_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.prep) begin
			idx_q <= '0;
		end else if (cmd.scan_rd || cmd.idx_inc) begin
			idx_q <= SW'(idx_q + 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			slot_fired_q <= '0;
		end else begin
			if (cmd.alloc) begin
				slot_valid_q[idx_q] <= 1'b1;
				slot_fired_q[idx_q] <= 1'b0;
			end
			if (cmd.stop_do && slot_hit) begin
				slot_valid_q[slot_sel] <= 1'b0;
			end
			if (fire) begin
				slot_fired_q[idx_s1] <= 1'b1;
			end
		end
	end

	// Reference time: written by start and by each firing.
	assign ref_we = cmd.alloc || fire;
	assign ref_wa = cmd.alloc ? idx_q : idx_s1;

	always_ff @(posedge clk) begin
		if (ref_we) begin
			ref_mem[ref_wa] <= now_q;
		end
		if (cmd.scan_rd) begin
			ref_s1 <= ref_mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.alloc) begin
			dly_mem[idx_q] <= item_q.first_delay;
		end
		if (cmd.scan_rd) begin
			dly_s1 <= dly_mem[idx_q];
		end
	end

	assign per_we = cmd.alloc || (cmd.rep_do && slot_hit);
	assign per_wa = cmd.alloc ? idx_q : slot_sel;
	assign per_wd = item_q.period;

	always_ff @(posedge clk) begin
		if (per_we) begin
			per_mem[per_wa] <= per_wd;
		end
		if (cmd.scan_rd) begin
			per_s1 <= per_mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_rd) begin
			idx_s1 <= idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= cmd.scan_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			mask_q     <= '0;
			assigned_q <= '0;
			full_q     <= 1'b0;
		end else begin
			if (fire && (32'(idx_s1) < 32'(MASK_W))) begin
				mask_q[OUT_IDX_W'(idx_s1)] <= 1'b1;
			end
			if (cmd.alloc) begin
				assigned_q <= OUT_IDX_W'(idx_q);
			end
			if (cmd.set_full) begin
				full_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.fired_mask    <= mask_q;
			out_q.assigned_slot <= assigned_q;
			out_q.table_full    <= full_q;
			out_q.now_ms        <= now_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign status.op       = item_q.op;
	assign status.idx_last = (idx_q == SW'(SLOTS - 1));
	assign status.cur_free = !slot_valid_q[idx_q];
	assign status.out_room = !out_valid_q || !out_stall;

endmodule

>>> rtl/multi_slot_oneshot_periodic_timer.sv
// ----------------------------------------------------------------------------
// multi_slot_oneshot_periodic_timer: table of one-shot and periodic timers
// Millisecond ticks advance the time and report the slots that fired; start,
// stop and set-repeat manage the slots.
//
//   channel   direction   handshake            word
//   in        into block  in_valid / in_stall   in_word_t
//   out       out of it   out_valid / out_stall out_word_t
//
// A tick walks the whole table in the compare stage, which visits one slot per
// cycle through the slot memories. A start looks for the lowest free slot;
// stop and set-repeat act on their named slot without a walk. One word is
// worked on at a time, and a new word is taken while the previous result
// still waits in the output register.
// Reset clears the time, the slot flags and the handshakes; the slot
// memories need no clearing. A stalled output only holds back the next result.
// ----------------------------------------------------------------------------
module multi_slot_oneshot_periodic_timer
	import mspt_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_data
);

	cmd_t    cmd;
	status_t status;

	mspt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	mspt_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (in_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

>>> rtl/mspt_chk.sv
// ----------------------------------------------------------------------------
// mspt_chk: port checks for the multi-slot timer
// Watches the top-level ports and is attached to every instance by bind.
// ----------------------------------------------------------------------------
module mspt_chk
	import mspt_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input in_word_t  in_data,
	input logic      out_valid,
	input logic      out_stall,
	input out_word_t out_data
);

	// A waiting input word stays put until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_data))
		else $error("input word changed while stalled");

	// A waiting result word stays put until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// One word at a time: the input closes right after a word is taken.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input still open after a word was taken");

	// A new result only comes out of a busy block.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a word in progress");

	// A full table answer carries no slot and no firing.
	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.table_full |->
			(out_data.assigned_slot == '0) && (out_data.fired_mask == '0))
		else $error("full-table result carries other fields");

endmodule

bind multi_slot_oneshot_periodic_timer mspt_chk u_mspt_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

>>> tb/tb_multi_slot_oneshot_periodic_timer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_slot_oneshot_periodic_timer: self-checking bench for the timer table
// A directed opening and a long random run of ticks, starts, stops and
// set-repeats go into the block. A local predictor computes each result word,
// and a scoreboard compares every output word field by field. Both channels
// idle and stall at random, and the receiver once holds off long enough to
// back the block up.
// ----------------------------------------------------------------------------
module tb_multi_slot_oneshot_periodic_timer;
	import mspt_pkg::*;

	localparam int SLOTS      = SLOTS_DEF;
	localparam int RAND_WORDS = 550;
	localparam int QUIET_MAX  = 2000;
	localparam int HOLD_AT    = 300;
	localparam int HOLD_LEN   = 300;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_stall;
	in_word_t  in_data   = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_word_t out_data;

	multi_slot_oneshot_periodic_timer #(.SLOTS(SLOTS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always #4 clk = ~clk;

	// Predicted timer state.
	logic [31:0] clock_ms = '0;
	bit          slot_live [SLOTS];
	bit          slot_fired [SLOTS];
	logic [31:0] slot_ref [SLOTS];
	logic [31:0] slot_dly [SLOTS];
	logic [31:0] slot_per [SLOTS];

	// Occupancy as seen while the stimulus is built, used to aim stops and
	// set-repeats mostly at live slots.
	bit          plan_live [SLOTS];

	in_word_t    cmd_q [$];
	out_word_t   result_q [$];
	int          n_words;
	int          n_sent = 0;
	int          n_errors = 0;
	int          quiet_cycles = 0;

	function automatic out_word_t timer_table_step(in_word_t w);
		out_word_t   r;
		logic [31:0] elapsed;
		logic [31:0] lim;
		r = '0;
		case (w.op)
			OP_TICK: begin
				clock_ms = clock_ms + 32'd1;
				for (int s = 0; s < SLOTS; s++) begin
					if (slot_live[s]) begin
						elapsed = clock_ms - slot_ref[s];
						lim = slot_fired[s] ? slot_per[s] : slot_dly[s];
						if (elapsed >= lim) begin
							slot_fired[s] = 1'b1;
							slot_ref[s] = clock_ms;
							r.fired_mask[s] = 1'b1;
						end
					end
				end
			end
			OP_START: begin
				r.table_full = 1'b1;
				for (int s = 0; s < SLOTS; s++) begin
					if (!slot_live[s] && r.table_full) begin
						slot_live[s] = 1'b1;
						slot_fired[s] = 1'b0;
						slot_ref[s] = clock_ms;
						slot_dly[s] = w.first_delay;
						slot_per[s] = w.period;
						r.assigned_slot = s[3:0];
						r.table_full = 1'b0;
					end
				end
			end
			OP_STOP: begin
				if (slot_live[w.timer_slot])
					slot_live[w.timer_slot] = 1'b0;
			end
			default: begin
				if (slot_live[w.timer_slot])
					slot_per[w.timer_slot] = w.period;
			end
		endcase
		r.now_ms = clock_ms;
		return r;
	endfunction

	task automatic add_word(op_t op, logic [3:0] slot, logic [31:0] dly, logic [31:0] per);
		in_word_t w;
		bit       done;
		w.op = op;
		w.timer_slot = slot;
		w.first_delay = dly;
		w.period = per;
		cmd_q.insert(cmd_q.size(), w);
		done = 1'b0;
		if (op == OP_START) begin
			for (int s = 0; s < SLOTS; s++) begin
				if (!plan_live[s] && !done) begin
					plan_live[s] = 1'b1;
					done = 1'b1;
				end
			end
		end else if (op == OP_STOP) begin
			plan_live[slot] = 1'b0;
		end
	endtask

	function automatic logic [3:0] pick_slot();
		int live_list [$];
		for (int s = 0; s < SLOTS; s++)
			if (plan_live[s])
				live_list.insert(live_list.size(), s);
		if (live_list.size() != 0 && $urandom_range(0, 99) < 85)
			return 4'(live_list[$urandom_range(0, live_list.size() - 1)]);
		return 4'($urandom_range(0, 15));
	endfunction

	// Mostly short times so that slots fire often, sometimes full-width values.
	function automatic logic [31:0] pick_ms();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return 32'($urandom_range(0, 12));
		else if (r < 9)
			return $urandom;
		return 32'($urandom_range(0, 60));
	endfunction

	initial begin
		int r;
		// Empty table: tick, then stop and set-repeat on free slots.
		add_word(OP_TICK, 4'd0, 32'd0, 32'd0);
		add_word(OP_STOP, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_word(OP_REPEAT, 4'd15, 32'd0, 32'd7);
		// Zero delay and period, widest delay and period, then a short one.
		add_word(OP_START, 4'd0, 32'd0, 32'd0);
		add_word(OP_START, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_word(OP_START, 4'd0, 32'd2, 32'd1);
		add_word(OP_TICK, 4'd0, 32'd0, 32'd0);
		add_word(OP_TICK, 4'd0, 32'd0, 32'd0);
		add_word(OP_REPEAT, 4'd0, 32'd0, 32'd3);
		for (int i = 0; i < SLOTS - 3; i++)
			add_word(OP_START, 4'd0, 32'(i % 3), 32'(i));
		// No free slot left.
		add_word(OP_START, 4'd0, 32'd1, 32'd1);
		add_word(OP_TICK, 4'd0, 32'd0, 32'd0);
		add_word(OP_STOP, 4'd15, 32'd0, 32'd0);

		for (int i = 0; i < RAND_WORDS; i++) begin
			r = $urandom_range(0, 99);
			if (r < 2) begin
				for (int k = 0; k <= SLOTS; k++)
					add_word(OP_START, 4'($urandom), pick_ms(), pick_ms());
			end else if (r < 52) begin
				add_word(OP_TICK, 4'($urandom), $urandom, $urandom);
			end else if (r < 70) begin
				add_word(OP_START, 4'($urandom), pick_ms(), pick_ms());
			end else if (r < 85) begin
				add_word(OP_STOP, pick_slot(), $urandom, $urandom);
			end else begin
				add_word(OP_REPEAT, pick_slot(), $urandom, pick_ms());
			end
		end
		n_words = cmd_q.size();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (n_sent == n_words);
		wait (result_q.size() == 0);
		repeat (SLOTS + 8) @(posedge clk);
		if (n_errors == 0)
			$display("multi_slot_oneshot_periodic_timer regression: pass");
		else
			$display("multi_slot_oneshot_periodic_timer regression: fail");
		$finish;
	end

	// Sender: after each accepted word it waits a drawn number of cycles.
	int tx_wait;
	bit tx_calm;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
			tx_wait  <= 0;
			tx_calm  <= 1'b0;
		end else begin
			bit busy;
			int w;
			busy = in_valid;
			w = tx_wait;
			if (in_valid && !in_stall) begin
				busy = 1'b0;
				n_sent <= n_sent + 1;
				if ($urandom_range(0, 31) == 0)
					tx_calm <= !tx_calm;
				w = tx_calm ? 0 : $urandom_range(0, 16);
			end
			if (!busy) begin
				if (w == 0 && cmd_q.size() != 0) begin
					in_valid <= 1'b1;
					in_data <= cmd_q.pop_front();
				end else begin
					in_valid <= 1'b0;
					if (w > 0)
						w = w - 1;
				end
			end
			tx_wait <= w;
		end
	end

	// One long hold-off of the receiver while the sender keeps offering words.
	bit hold_on;
	bit hold_done;
	int hold_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_on   <= 1'b0;
			hold_done <= 1'b0;
			hold_left <= 0;
		end else if (!hold_done && !hold_on && n_sent >= HOLD_AT) begin
			hold_on   <= 1'b1;
			hold_left <= HOLD_LEN;
		end else if (hold_on) begin
			if (hold_left == 1) begin
				hold_on   <= 1'b0;
				hold_done <= 1'b1;
			end
			hold_left <= hold_left - 1;
		end
	end

	// Receiver: stalls for a drawn number of cycles after each accepted word.
	int rx_wait;
	bit rx_calm;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_wait   <= 0;
			rx_calm   <= 1'b0;
		end else begin
			int w;
			w = rx_wait;
			if (out_valid && !out_stall) begin
				if ($urandom_range(0, 31) == 0)
					rx_calm <= !rx_calm;
				w = rx_calm ? 0 : $urandom_range(0, 16);
			end else if (w > 0) begin
				w = w - 1;
			end
			rx_wait <= w;
			out_stall <= hold_on || (w != 0);
		end
	end

	// Scoreboard: the output side is checked before the input side is
	// predicted, since no word can come out on the edge it went in.
	always @(posedge clk) begin
		out_word_t exp_w;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (result_q.size() == 0) begin
					$error("result word with none expected: %h", out_data);
					n_errors++;
				end else begin
					exp_w = result_q.pop_front();
					if (out_data.fired_mask !== exp_w.fired_mask) begin
						$error("fired_mask: expected %h, actual %h",
							exp_w.fired_mask, out_data.fired_mask);
						n_errors++;
					end
					if (out_data.assigned_slot !== exp_w.assigned_slot) begin
						$error("assigned_slot: expected %0d, actual %0d",
							exp_w.assigned_slot, out_data.assigned_slot);
						n_errors++;
					end
					if (out_data.table_full !== exp_w.table_full) begin
						$error("table_full: expected %b, actual %b",
							exp_w.table_full, out_data.table_full);
						n_errors++;
					end
					if (out_data.now_ms !== exp_w.now_ms) begin
						$error("now_ms: expected %0d, actual %0d",
							exp_w.now_ms, out_data.now_ms);
						n_errors++;
					end
				end
			end
			if (in_valid && !in_stall)
				result_q.insert(result_q.size(), timer_table_step(in_data));
		end
	end

	// Watchdog on cycles in which neither channel moves a word.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_MAX) begin
				$display("multi_slot_oneshot_periodic_timer regression: fail");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

endmodule
